[rtl/rgbtp_pkg.sv]
// Shared types, codes and character helpers for the RGB triple line parser.
package rgbtp_pkg;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_SIGN   = 2'd1,
		PH_DIGITS = 2'd2
	} phase_t;

	localparam logic [8:0] MAG_SAT = 9'd256;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef struct packed {
		logic [1:0] field_index;
		phase_t     scan_phase;
		logic       negative;
		logic [8:0] magnitude;
		logic [7:0] first_value;
		logic [7:0] second_value;
		logic       line_failed;
		logic       line_done;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{
		field_index:  2'd0,
		scan_phase:   PH_SKIP,
		negative:     1'b0,
		magnitude:    9'd0,
		first_value:  8'd0,
		second_value: 8'd0,
		line_failed:  1'b0,
		line_done:    1'b0
	};

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       valid_res;
	} rgb_result_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic [7:0] clamped(input logic neg, input logic [8:0] mag);
		logic [7:0] v;
		if (neg) begin
			v = 8'd0;
		end else if (mag[8]) begin
			v = 8'hFF;
		end else begin
			v = mag[7:0];
		end
		return v;
	endfunction

endpackage

[rtl/rgbtp_scan.sv]
// Character scanner: parse state registers and per-character next-state logic.
module rgbtp_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            ch,
	input  logic                  line_end,
	output rgbtp_pkg::rgb_result_t res
);

	rgbtp_pkg::scan_state_t state_q;
	rgbtp_pkg::scan_state_t state_n;
	rgbtp_pkg::scan_state_t parsed;
	logic [3:0]  digit;
	logic [11:0] mag_acc;
	logic        do_start;
	logic        ok;

	assign digit = ch[3:0];
	assign mag_acc = {3'd0, state_q.magnitude} * 12'd10 + {8'd0, digit};

	// next state
	always_comb begin
		parsed = state_q;
		do_start = 1'b0;
		if (!state_q.line_done && !state_q.line_failed) begin
			unique case (state_q.scan_phase)
				rgbtp_pkg::PH_SIGN: begin
					if (rgbtp_pkg::is_digit(ch)) begin
						parsed.magnitude = {5'd0, digit};
						parsed.scan_phase = rgbtp_pkg::PH_DIGITS;
					end else begin
						parsed.line_failed = 1'b1;
					end
				end
				rgbtp_pkg::PH_DIGITS: begin
					if (rgbtp_pkg::is_digit(ch)) begin
						parsed.magnitude = (mag_acc > 12'd256) ? rgbtp_pkg::MAG_SAT
							: mag_acc[8:0];
					end else if (state_q.field_index[1]) begin
						// third number done; the rest of the line is ignored
						parsed.line_done = 1'b1;
					end else begin
						if (state_q.field_index == 2'd0) begin
							parsed.first_value = rgbtp_pkg::clamped(state_q.negative,
								state_q.magnitude);
						end else begin
							parsed.second_value = rgbtp_pkg::clamped(state_q.negative,
								state_q.magnitude);
						end
						parsed.field_index = state_q.field_index + 2'd1;
						parsed.scan_phase = rgbtp_pkg::PH_SKIP;
						do_start = 1'b1;
					end
				end
				default: do_start = 1'b1;
			endcase
			if (do_start && !rgbtp_pkg::is_ws(ch)) begin
				if (ch == rgbtp_pkg::CH_PLUS || ch == rgbtp_pkg::CH_MINUS) begin
					parsed.negative = (ch == rgbtp_pkg::CH_MINUS);
					parsed.magnitude = 9'd0;
					parsed.scan_phase = rgbtp_pkg::PH_SIGN;
				end else if (rgbtp_pkg::is_digit(ch)) begin
					parsed.negative = 1'b0;
					parsed.magnitude = {5'd0, digit};
					parsed.scan_phase = rgbtp_pkg::PH_DIGITS;
				end else begin
					parsed.line_failed = 1'b1;
				end
			end
		end
		// line end inside the third number completes it
		if (line_end && !parsed.line_done && !parsed.line_failed) begin
			if (parsed.scan_phase == rgbtp_pkg::PH_DIGITS && parsed.field_index[1]) begin
				parsed.line_done = 1'b1;
			end else begin
				parsed.line_failed = 1'b1;
			end
		end
		state_n = line_end ? rgbtp_pkg::SCAN_RESET : parsed;
	end

	// result
	always_comb begin
		ok = parsed.line_done && !parsed.line_failed;
		res.red = ok ? parsed.first_value : 8'd0;
		res.green = ok ? parsed.second_value : 8'd0;
		res.blue = ok ? rgbtp_pkg::clamped(parsed.negative, parsed.magnitude) : 8'd0;
		res.valid_res = ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgbtp_pkg::SCAN_RESET;
		end else if (step) begin
			state_q <= state_n;
		end
	end

endmodule

[rtl/rgb_triple_line_parser.sv]
// Top level of the RGB triple line parser: input register, scanner, result register.
// Takes one character per cycle unless stalled; each character is captured in an input register,
// is folded into the parse state, and the request flagged line_end leaves one result
// (red, green, blue, valid_res) in the output register once that register is free to take it.
// Sustained rate is one character per clock, set by the single scanner state update;
// a stalled result holds back the next line_end character and the input behind it.
module rgb_triple_line_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] ch,
	input  logic       line_end,
	output logic       rgb_valid,
	input  logic       rgb_stall,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic       valid_res
);

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       line_end_s1;
	logic       out_free;
	logic       proc;
	rgbtp_pkg::rgb_result_t res;

	assign out_free = !rgb_valid || !rgb_stall;
	assign proc = valid_s1 && (!line_end_s1 || out_free);
	assign char_stall = valid_s1 && !proc;

	rgbtp_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (proc),
		.ch       (ch_s1),
		.line_end (line_end_s1),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rgb_valid <= 1'b0;
		end else begin
			if (!char_stall) begin
				valid_s1 <= char_valid;
			end
			if (out_free) begin
				rgb_valid <= proc && line_end_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			ch_s1 <= ch;
			line_end_s1 <= line_end;
		end
		if (out_free && proc && line_end_s1) begin
			red <= res.red;
			green <= res.green;
			blue <= res.blue;
			valid_res <= res.valid_res;
		end
	end

endmodule
